// ----- rtl/delta_list_sleep_timer_queue_unit_assert.svh -----
// assertion helpers for the sleep timer queue
`ifndef DELTA_LIST_SLEEP_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DELTA_LIST_SLEEP_TIMER_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DLSTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define DLSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dlstq_pkg.sv -----
package dlstq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int TIME_BITS_DEF   = 16;
    localparam int CNT_BITS_DEF    = $clog2(QUEUE_DEPTH_DEF + 1);

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // storage read address select
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_PREV = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    // storage write data select
    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_NEW      = 3'd1,
        WR_COPY     = 3'd2,
        WR_COPY_SUB = 3'd3,
        WR_COPY_ADD = 3'd4,
        WR_DEC      = 3'd5
    } t_wr_sel;

    typedef struct packed {
        logic    in_ready;
        logic    load_req;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_from_count;
        logic    pos_from_idx;
        logic    d_sub;
        logic    save_delta;
        logic    save_head;
        logic    save_next;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    out_load;
        t_status out_status;
        logic    out_exp;
        logic    out_last;
        logic    out_head;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] req;
        logic       full;
        logic       count_zero;
        logic       idx_lt_count;
        logic       idx_p1_lt_count;
        logic       idx_eq_pos;
        logic       idx_m1_eq_pos;
        logic       rd_delta_le_d;
        logic       rd_delta_zero;
        logic       rd_delta_one;
        logic       rd_task_eq_id;
        logic       next_zero;
        logic       out_free;
    } t_sts;

endpackage

// ----- rtl/dlstq_req_if.sv -----
interface dlstq_req_if import dlstq_pkg::*; #(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] delay;

    modport source (output valid, req_type, task_id, delay, input ready);
    modport sink   (input valid, req_type, task_id, delay, output ready);
endinterface

// ----- rtl/dlstq_res_if.sv -----
interface dlstq_res_if import dlstq_pkg::*; #(
    parameter int ID_BITS  = ID_BITS_DEF,
    parameter int CNT_BITS = CNT_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ID_BITS-1:0]  task_id_res;
    logic                expired;
    logic                last;
    logic [CNT_BITS-1:0] occupancy;

    modport source (output valid, status, task_id_res, expired, last, occupancy, input ready);
    modport sink   (input valid, status, task_id_res, expired, last, occupancy, output ready);
endinterface

// ----- rtl/dlstq_ctrl.sv -----
module dlstq_ctrl import dlstq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INS_RD,
        S_INS_EX,
        S_INS_SH_RD,
        S_INS_SH_WR,
        S_REM_RD,
        S_REM_EX,
        S_DROP_RD,
        S_DROP_WR,
        S_TCK_RD,
        S_TCK_EX,
        S_TCK_NX,
        S_TCK_HD,
        S_TCK_OUT,
        S_RESP
    } t_state;

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_IDX;
        o_cmd.wr_sel = WR_NONE;
        n_state      = r_state;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req)
                    REQ_INSERT: begin
                        if (i_sts.full) begin
                            n_res_status = ST_FULL;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    REQ_TICK:   n_state = i_sts.count_zero ? S_IDLE : S_TCK_RD;
                    REQ_REMOVE: n_state = S_REM_RD;
                    default:    n_state = S_IDLE;
                endcase
            end
            // walk: subtract deltas not larger than what is left
            S_INS_RD: begin
                if (i_sts.idx_lt_count) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_INS_EX;
                end else begin
                    o_cmd.pos_from_idx   = 1'b1;
                    o_cmd.idx_from_count = 1'b1;
                    n_state              = S_INS_SH_RD;
                end
            end
            S_INS_EX: begin
                if (i_sts.rd_delta_le_d) begin
                    o_cmd.d_sub   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_INS_RD;
                end else begin
                    o_cmd.pos_from_idx   = 1'b1;
                    o_cmd.idx_from_count = 1'b1;
                    n_state              = S_INS_SH_RD;
                end
            end
            // open a hole at pos, top entry first
            S_INS_SH_RD: begin
                if (i_sts.idx_eq_pos) begin
                    o_cmd.wr_sel  = WR_NEW;
                    o_cmd.cnt_inc = 1'b1;
                    n_res_status  = ST_OK;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_SH_WR;
                end
            end
            S_INS_SH_WR: begin
                o_cmd.wr_sel  = i_sts.idx_m1_eq_pos ? WR_COPY_SUB : WR_COPY;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_INS_SH_RD;
            end
            S_REM_RD: begin
                if (i_sts.idx_lt_count) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_REM_EX;
                end else begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_RESP;
                end
            end
            S_REM_EX: begin
                if (i_sts.rd_task_eq_id) begin
                    o_cmd.save_delta   = 1'b1;
                    o_cmd.pos_from_idx = 1'b1;
                    n_state            = S_DROP_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_REM_RD;
                end
            end
            // close the gap at pos, shared by remove and tick
            S_DROP_RD: begin
                if (i_sts.idx_p1_lt_count) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DROP_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    if (i_sts.req == REQ_TICK) begin
                        n_state = S_TCK_OUT;
                    end else begin
                        n_res_status = ST_OK;
                        n_state      = S_RESP;
                    end
                end
            end
            S_DROP_WR: begin
                if (i_sts.idx_eq_pos && i_sts.req == REQ_REMOVE) begin
                    o_cmd.wr_sel = WR_COPY_ADD;
                end else begin
                    o_cmd.wr_sel = WR_COPY;
                end
                o_cmd.save_next = i_sts.idx_eq_pos;
                o_cmd.idx_inc   = 1'b1;
                n_state         = S_DROP_RD;
            end
            S_TCK_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_TCK_EX;
            end
            S_TCK_EX: begin
                if (i_sts.rd_delta_zero || i_sts.rd_delta_one) begin
                    o_cmd.save_head    = 1'b1;
                    o_cmd.pos_from_idx = 1'b1;
                    n_state            = S_DROP_RD;
                end else begin
                    o_cmd.wr_sel = WR_DEC;
                    n_state      = S_IDLE;
                end
            end
            S_TCK_NX: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_TCK_HD;
            end
            S_TCK_HD: begin
                o_cmd.save_head    = 1'b1;
                o_cmd.pos_from_idx = 1'b1;
                n_state            = S_DROP_RD;
            end
            S_TCK_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_exp    = 1'b1;
                    o_cmd.out_head   = 1'b1;
                    o_cmd.out_last   = i_sts.count_zero || !i_sts.next_zero;
                    if (i_sts.count_zero || !i_sts.next_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_TCK_NX;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_res_status;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
        end
    end

endmodule

// ----- rtl/dlstq_dpath.sv -----
`include "delta_list_sleep_timer_queue_unit_assert.svh"

module dlstq_dpath import dlstq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    dlstq_req_if.sink    i_req,
    dlstq_res_if.source  o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [ID_BITS-1:0]   mem_task  [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] mem_delta [QUEUE_DEPTH];

    logic [1:0]           r_req;
    logic [ID_BITS-1:0]   r_id, r_head, r_rd_task;
    logic [TIME_BITS-1:0] r_d, r_save, r_rd_delta;
    logic                 r_next_zero;
    logic [CW-1:0]        r_count, r_idx, r_pos;

    logic                 r_o_valid;
    t_status              r_o_status;
    logic [ID_BITS-1:0]   r_o_id;
    logic                 r_o_exp, r_o_last;
    logic [CW-1:0]        r_o_occ;

    logic [CW-1:0]        idx_m1, idx_p1;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [ID_BITS-1:0]   wr_task;
    logic [TIME_BITS-1:0] wr_delta;
    logic                 out_free;

    assign idx_m1   = r_idx - CW'(1);
    assign idx_p1   = r_idx + CW'(1);
    assign wr_addr  = r_idx[AW-1:0];
    assign out_free = !r_o_valid || o_res.ready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: rd_addr = idx_m1[AW-1:0];
            RD_NEXT: rd_addr = idx_p1[AW-1:0];
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_comb begin
        wr_task  = r_rd_task;
        wr_delta = r_rd_delta;
        case (i_cmd.wr_sel)
            WR_NEW: begin
                wr_task  = r_id;
                wr_delta = r_d;
            end
            WR_COPY_SUB: wr_delta = r_rd_delta - r_d;
            WR_COPY_ADD: wr_delta = r_rd_delta + r_save;
            WR_DEC:      wr_delta = r_rd_delta - TIME_BITS'(1);
            default:     wr_delta = r_rd_delta;
        endcase
    end

    // entry storage, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sel != WR_NONE) begin
            mem_task[wr_addr]  <= wr_task;
            mem_delta[wr_addr] <= wr_delta;
        end
        if (i_cmd.rd_en) begin
            r_rd_task  <= mem_task[rd_addr];
            r_rd_delta <= mem_delta[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req.req_type;
            r_id  <= i_req.task_id;
            r_d   <= i_req.delay;
        end else if (i_cmd.d_sub) begin
            r_d <= r_d - r_rd_delta;
        end
        if (i_cmd.save_delta) begin
            r_save <= r_rd_delta;
        end
        if (i_cmd.save_head) begin
            r_head <= r_rd_task;
        end
        if (i_cmd.save_next) begin
            r_next_zero <= (r_rd_delta == '0);
        end
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.out_status;
            r_o_id     <= i_cmd.out_head ? r_head : r_id;
            r_o_exp    <= i_cmd.out_exp;
            r_o_last   <= i_cmd.out_last;
            r_o_occ    <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_from_count) begin
                r_idx <= r_count;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_p1;
            end else if (i_cmd.idx_dec) begin
                r_idx <= idx_m1;
            end
            if (i_cmd.pos_from_idx) begin
                r_pos <= r_idx;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.in_valid        = i_req.valid;
        o_sts.req             = r_req;
        o_sts.full            = (r_count == CW'(QUEUE_DEPTH));
        o_sts.count_zero      = (r_count == '0);
        o_sts.idx_lt_count    = (r_idx < r_count);
        o_sts.idx_p1_lt_count = ({1'b0, r_idx} + (CW + 1)'(1)) < {1'b0, r_count};
        o_sts.idx_eq_pos      = (r_idx == r_pos);
        o_sts.idx_m1_eq_pos   = (idx_m1 == r_pos);
        o_sts.rd_delta_le_d   = (r_rd_delta <= r_d);
        o_sts.rd_delta_zero   = (r_rd_delta == '0);
        o_sts.rd_delta_one    = (r_rd_delta == TIME_BITS'(1));
        o_sts.rd_task_eq_id   = (r_rd_task == r_id);
        o_sts.next_zero       = r_next_zero;
        o_sts.out_free        = out_free;
    end

    assign i_req.ready       = i_cmd.in_ready;
    assign o_res.valid       = r_o_valid;
    assign o_res.status      = r_o_status;
    assign o_res.task_id_res = r_o_id;
    assign o_res.expired     = r_o_exp;
    assign o_res.last        = r_o_last;
    assign o_res.occupancy   = r_o_occ;

    `DLSTQ_ASSERT_NOW(a_no_grow_when_full, i_cmd.cnt_inc, r_count < CW'(QUEUE_DEPTH), "insert into full queue")
    `DLSTQ_ASSERT_NOW(a_no_shrink_when_empty, i_cmd.cnt_dec, r_count != '0, "drop from empty queue")
    `DLSTQ_ASSERT_NOW(a_no_result_overwrite, i_cmd.out_load, out_free, "pending result overwritten")
    `DLSTQ_ASSERT_NOW(a_write_in_range, i_cmd.wr_sel != WR_NONE, r_idx < CW'(QUEUE_DEPTH), "write past depth")
    `DLSTQ_ASSERT_NEXT(a_occ_tracks_count, i_cmd.out_load, o_res.occupancy == $past(r_count), "bad occupancy")

endmodule

// ----- rtl/delta_list_sleep_timer_queue_unit.sv -----
// insert: one result; remove: one result
// tick: one result per expired task, the head first, then each further one
// that is due with it; nothing due gives no result and frees the input
// one item in work at a time
// reset: synchronous active low, queue empty, no result pending; entry store is not cleared
module delta_list_sleep_timer_queue_unit import dlstq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dlstq_req_if.sink    i_req,
    dlstq_res_if.source  o_res
);

    // command and status bundles between sequencer and queue datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: walk, shift, expire and answer phases
    dlstq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: entry store, walk pointers, entry count and result register
    dlstq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

// ----- sim/dlstq_wake_checker.sv -----
module dlstq_wake_checker import dlstq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dlstq_req_if i_req,
    dlstq_res_if i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int ID_W   = ID_BITS_DEF;
    localparam int TIME_W = TIME_BITS_DEF;
    localparam int CNT_W  = CNT_BITS_DEF;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  task_id;
        logic             expired;
        logic             last;
        logic [CNT_W-1:0] occupancy;
    } wake_note_t;

    // shadow of the delta list, head at index 0
    logic [ID_W-1:0]   sleeper_id    [DEPTH];
    logic [TIME_W-1:0] sleeper_delta [DEPTH];
    int                sleeper_count = 0;

    wake_note_t due_results [$];
    int         mismatches = 0;

    task automatic note_result(input t_status st, input logic [ID_W-1:0] id,
                               input logic exp, input logic fin);
        wake_note_t n;
        n.status    = st;
        n.task_id   = id;
        n.expired   = exp;
        n.last      = fin;
        n.occupancy = sleeper_count[CNT_W-1:0];
        due_results.push_back(n);
    endtask

    // close the gap at pos
    task automatic drop_sleeper(input int pos);
        int i;
        for (i = pos; i + 1 < sleeper_count; i++) begin
            sleeper_id[i]    = sleeper_id[i + 1];
            sleeper_delta[i] = sleeper_delta[i + 1];
        end
        sleeper_count--;
    endtask

    task automatic advance_sleep_queue(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                       input logic [TIME_W-1:0] dly);
        int                pos;
        int                i;
        logic [TIME_W-1:0] rest;
        logic [ID_W-1:0]   woken;
        logic              fin;
        rest = dly;
        case (kind)
            REQ_INSERT: begin
                if (sleeper_count >= DEPTH) begin
                    note_result(ST_FULL, id, 1'b0, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < sleeper_count && sleeper_delta[pos] <= rest) begin
                        rest -= sleeper_delta[pos];
                        pos++;
                    end
                    if (pos < sleeper_count)
                        sleeper_delta[pos] -= rest;
                    for (i = sleeper_count; i > pos; i--) begin
                        sleeper_id[i]    = sleeper_id[i - 1];
                        sleeper_delta[i] = sleeper_delta[i - 1];
                    end
                    sleeper_id[pos]    = id;
                    sleeper_delta[pos] = rest;
                    sleeper_count++;
                    note_result(ST_OK, id, 1'b0, 1'b1);
                end
            end
            REQ_TICK: begin
                if (sleeper_count > 0) begin
                    if (sleeper_delta[0] != '0)
                        sleeper_delta[0]--;
                    while (sleeper_count > 0 && sleeper_delta[0] == '0) begin
                        woken = sleeper_id[0];
                        drop_sleeper(0);
                        fin = (sleeper_count == 0) || (sleeper_delta[0] != '0);
                        note_result(ST_OK, woken, 1'b1, fin);
                    end
                end
            end
            REQ_REMOVE: begin
                pos = 0;
                while (pos < sleeper_count && sleeper_id[pos] != id)
                    pos++;
                if (pos >= sleeper_count) begin
                    note_result(ST_NOT_FOUND, id, 1'b0, 1'b1);
                end else begin
                    if (pos + 1 < sleeper_count)
                        sleeper_delta[pos + 1] = sleeper_delta[pos + 1] + sleeper_delta[pos];
                    drop_sleeper(pos);
                    note_result(ST_OK, id, 1'b0, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        wake_note_t seen;
        wake_note_t want;
        if (!i_rst_n) begin
            sleeper_count = 0;
            due_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.status    = t_status'(i_res.status);
                seen.task_id   = i_res.task_id_res;
                seen.expired   = i_res.expired;
                seen.last      = i_res.last;
                seen.occupancy = i_res.occupancy;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: status=%0d id=%0d expired=%0b last=%0b occ=%0d",
                             $time, seen.status, seen.task_id, seen.expired, seen.last,
                             seen.occupancy);
                end else begin
                    want = due_results.pop_front();
                    if (seen.status !== want.status || seen.task_id !== want.task_id ||
                        seen.expired !== want.expired || seen.last !== want.last ||
                        seen.occupancy !== want.occupancy) begin
                        mismatches++;
                        $display("%0t result mismatch: expected status=%0d id=%0d expired=%0b last=%0b occ=%0d",
                                 $time, want.status, want.task_id, want.expired, want.last,
                                 want.occupancy);
                        $display("%0t                  actual status=%0d id=%0d expired=%0b last=%0b occ=%0d",
                                 $time, seen.status, seen.task_id, seen.expired, seen.last,
                                 seen.occupancy);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                advance_sleep_queue(i_req.req_type, i_req.task_id, i_req.delay);
        end
        o_fail_count <= mismatches;
        o_pending    <= due_results.size();
    end

endmodule

// ----- sim/tb.sv -----
module tb;
    import dlstq_pkg::*;

    localparam int ID_W   = ID_BITS_DEF;
    localparam int TIME_W = TIME_BITS_DEF;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 140;
    localparam int CALM_ITEMS   = 30;    // final stretch with no idling on either side
    localparam int HOLD_AT      = 60;    // item count that triggers the long receiver hold-off
    localparam int HOLD_CYCLES  = 500;
    localparam int TAIL_CYCLES  = 200;   // covers a tick that finds nothing due
    localparam int CYCLE_LIMIT  = 1_000_000;

    // directed fill: zero delays, equal wake times, a duplicate id, extremes of both fields
    localparam logic [ID_W-1:0] FILL_IDS [16] = '{
        8'h00, 8'hFF, 8'h07, 8'h09, 8'h07, 8'h80, 8'h7F, 8'h55,
        8'hAA, 8'h01, 8'h02, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h10
    };
    localparam logic [TIME_W-1:0] FILL_DELAYS [16] = '{
        16'd0, 16'hFFFF, 16'd3, 16'd3, 16'd1, 16'd0, 16'd5, 16'd2,
        16'd2, 16'h8000, 16'h7FFF, 16'd10, 16'd1, 16'd4, 16'd6, 16'hAAAA
    };

    logic i_clk;
    logic i_rst_n;

    dlstq_req_if req_ch ();
    dlstq_res_if res_ch ();

    int fail_count;
    int pending_count;

    int cycle_count = 0;
    int items_sent  = 0;
    int gap_pct     = 25;
    bit calm        = 1'b0;
    bit hold_done   = 1'b0;

    // recently inserted ids, so most removes hit something
    logic [ID_W-1:0] recent_ids [16];
    int              recent_wr = 0;

    delta_list_sleep_timer_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    dlstq_wake_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // offer one item, optionally after an idle burst, and hold it until accepted
    task automatic send_item(input logic [1:0] kind, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] dly);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.task_id  <= id;
        req_ch.delay    <= dly;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
        if (kind == REQ_INSERT) begin
            recent_ids[recent_wr] = id;
            recent_wr = (recent_wr + 1) % 16;
        end
    endtask

    // result side: random stall bursts, long ready runs, one long hold-off
    initial begin : res_side
        int run;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                // sender keeps offering meanwhile, so the block backs up and drops ready
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int                rand_items;
        int                fill_left;
        int                roll;
        int                i;
        logic [1:0]        kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dly;

        rand_items = 0;
        fill_left  = 0;

        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.task_id  <= '0;
        req_ch.delay    <= '0;
        for (i = 0; i < 16; i++)
            recent_ids[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: tick gives nothing, remove misses, unused code ignored
        send_item(REQ_TICK, 8'h3C, 16'h1234);
        send_item(REQ_REMOVE, 8'h55, 16'h0000);
        send_item(REQ_UNUSED, 8'hA5, 16'h5A5A);

        // fill to capacity, then one more insert hits the full case
        for (i = 0; i < 16; i++)
            send_item(REQ_INSERT, FILL_IDS[i], FILL_DELAYS[i]);
        send_item(REQ_INSERT, 8'h5A, 16'h5555);

        // duplicate id goes nearest the head, tail removal, missing id
        send_item(REQ_REMOVE, 8'h07, 16'hFFFF);
        send_item(REQ_REMOVE, 8'hFF, 16'h0000);
        send_item(REQ_REMOVE, 8'h42, 16'h0000);

        // both zero-delay entries expire together
        send_item(REQ_TICK, 8'h00, 16'h0000);

        while (rand_items < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - rand_items <= CALM_ITEMS)
                calm = 1'b1;
            if (rand_items % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 25;
                    default: gap_pct = 60;
                endcase
            end

            roll = $urandom_range(0, 99);
            if (fill_left == 0 && roll < 3)
                fill_left = 18;    // insert run that pushes the queue toward full

            if (fill_left > 0) begin
                kind = REQ_INSERT;
                fill_left--;
            end else if (roll < 6) begin
                kind = REQ_UNUSED;
            end else if (roll < 50) begin
                kind = REQ_INSERT;
            end else if (roll < 84) begin
                kind = REQ_TICK;
            end else begin
                kind = REQ_REMOVE;
            end

            id = ID_W'($urandom_range(0, 255));
            if (kind == REQ_REMOVE && $urandom_range(0, 99) < 70)
                id = recent_ids[$urandom_range(0, 15)];

            // mostly short sleeps so ticks keep expiring tasks
            roll = $urandom_range(0, 99);
            if (roll < 65)
                dly = TIME_W'($urandom_range(0, 6));
            else if (roll < 88)
                dly = TIME_W'($urandom_range(0, 60));
            else
                dly = TIME_W'($urandom_range(0, 65535));

            send_item(kind, id, dly);
            if (kind != REQ_UNUSED)
                rand_items++;
        end
        req_ch.valid <= 1'b0;

        // wait for outstanding results, then a quiet tail for late extras
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
